[hdl/fcvf_pkg.sv]
// Shared types, constants and saturation helper for the friction contact velocity fix unit.
package fcvf_pkg;

    localparam int VW           = 32;
    localparam int MU_W         = 19;
    localparam int SQ_W         = 64;
    localparam int LEN_W        = 32;
    localparam int U_W          = 18;
    localparam int U_Q_W        = 17;
    localparam int U_DIVD_W     = 48;
    localparam int M_W          = VW + U_W;
    localparam int TD_W         = 35;
    localparam int TDM_W        = 34;
    localparam int R_DIVD_W     = 50;
    localparam int R_Q_W        = 32;
    localparam int FRONT_STAGES = 7;
    localparam int MID_STAGES   = 4;
    localparam int BACK_STAGES  = 5;
    localparam int PIPE_LAT     = FRONT_STAGES + LEN_W + U_Q_W + MID_STAGES + R_Q_W
                                  + BACK_STAGES;

    localparam logic [1:0] MODE_MASTER  = 2'd0;
    localparam logic [1:0] MODE_CONTACT = 2'd1;
    localparam logic [1:0] MODE_PASS    = 2'd2;
    localparam logic [1:0] MODE_SPARE   = 2'd3;

    localparam logic [VW-1:0] S32_MAX = 32'h7fff_ffff;
    localparam logic [VW-1:0] S32_MIN = 32'h8000_0000;

    typedef logic [VW-1:0] t_w;
    typedef logic [VW:0]   t_w33;

    typedef struct packed {
        t_w   [2:0] base;
        t_w33 [2:0] vmn;
        t_w   [2:0] dv;
        t_w         nd;
        logic       applied;
    } t_carry;

    typedef struct packed {
        t_carry     c;
        t_w   [2:0] t;
    } t_sq_pl;

    typedef struct packed {
        t_carry     c;
        logic       lenz;
        logic [2:0] tneg;
    } t_ud_pl;

    typedef struct packed {
        t_carry              c;
        logic [2:0][U_W-1:0] u;
        logic                tdneg;
        logic                ovf;
    } t_rd_pl;

    function automatic t_w sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return S32_MAX;
        end else if (x < -64'sd2147483648) begin
            return S32_MIN;
        end else begin
            return x[VW-1:0];
        end
    endfunction

endpackage

[hdl/friction_contact_velocity_fix_unit.sv]
// Top level of the friction contact velocity fix unit.
// Fully pipelined: one item is taken on every cycle that start is high, and its result leaves
// the back stages with o_res_valid high for one cycle; busy stays low and the result side
// cannot stall. The path runs through the 32-stage square root of the squared tangent length,
// the 17-stage unit tangent divider and the 32-stage friction ratio divider, plus 16 stages of
// multiply and saturate steps. The friction coefficient write port is always ready; write it
// only while no item is in flight.
module friction_contact_velocity_fix_unit
    import fcvf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_item_mode,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [31:0] i_vel_z,
    input  logic signed [31:0] i_rigid_x,
    input  logic signed [31:0] i_rigid_y,
    input  logic signed [31:0] i_rigid_z,
    input  logic signed [31:0] i_surf_normal_x,
    input  logic signed [31:0] i_surf_normal_y,
    input  logic signed [31:0] i_surf_normal_z,
    input  logic signed [31:0] i_separation,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [MU_W-1:0]  i_cfg_friction_limit,
    output logic             o_res_valid,
    output logic signed [31:0] o_new_vel_x,
    output logic signed [31:0] o_new_vel_y,
    output logic signed [31:0] o_new_vel_z,
    output logic             o_contact_applied
);

    logic [MU_W-1:0] r_friction_limit;

    logic                       fr_valid;
    logic [SQ_W-1:0]            fr_sq;
    t_sq_pl                     fr_pl;
    logic                       sq_valid;
    logic [LEN_W-1:0]           sq_root;
    t_sq_pl                     sq_pl;
    logic [2:0][U_DIVD_W-1:0]   ud_dvd;
    t_ud_pl                     ud_pl_in;
    logic                       ud_valid;
    logic [2:0][U_Q_W-1:0]      ud_quot;
    t_ud_pl                     ud_pl;
    logic                       md_valid;
    logic [R_DIVD_W-1:0]        md_dvd;
    t_w                         md_dvs;
    t_rd_pl                     md_pl;
    logic                       rd_valid;
    logic [R_Q_W-1:0]           rd_quot;
    t_rd_pl                     rd_pl;
    t_w   [2:0]                 bk_vel;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_friction_limit <= '0;
        end else if (i_cfg_valid) begin
            r_friction_limit <= i_cfg_friction_limit;
        end
    end

    fcvf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_mode  (i_item_mode),
        .i_vel   ({i_vel_z, i_vel_y, i_vel_x}),
        .i_rigid ({i_rigid_z, i_rigid_y, i_rigid_x}),
        .i_norm  ({i_surf_normal_z, i_surf_normal_y, i_surf_normal_x}),
        .i_sep   (i_separation),
        .o_valid (fr_valid),
        .o_sq    (fr_sq),
        .o_pl    (fr_pl)
    );

    fcvf_sqrt #(
        .PW ($bits(t_sq_pl))
    ) u_sqrt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (fr_valid),
        .i_x       (fr_sq),
        .i_payload (fr_pl),
        .o_valid   (sq_valid),
        .o_root    (sq_root),
        .o_payload (sq_pl)
    );

    always_comb begin
        t_w tabs;
        for (int i = 0; i < 3; i++) begin
            ud_pl_in.tneg[i] = sq_pl.t[i][VW-1];
            tabs = sq_pl.t[i][VW-1] ? (VW'(0) - sq_pl.t[i]) : sq_pl.t[i];
            ud_dvd[i] = U_DIVD_W'(tabs) << 16;
        end
        ud_pl_in.c    = sq_pl.c;
        ud_pl_in.lenz = (sq_root == '0);
    end

    fcvf_udiv #(
        .LANES  (3),
        .DIVD_W (U_DIVD_W),
        .DIVS_W (LEN_W),
        .Q_W    (U_Q_W),
        .PW     ($bits(t_ud_pl))
    ) u_tan_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (sq_valid),
        .i_dividend (ud_dvd),
        .i_divisor  (sq_root),
        .i_payload  (ud_pl_in),
        .o_valid    (ud_valid),
        .o_quot     (ud_quot),
        .o_payload  (ud_pl)
    );

    fcvf_mid u_mid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (ud_valid),
        .i_quot     (ud_quot),
        .i_pl       (ud_pl),
        .o_valid    (md_valid),
        .o_dividend (md_dvd),
        .o_divisor  (md_dvs),
        .o_pl       (md_pl)
    );

    fcvf_udiv #(
        .LANES  (1),
        .DIVD_W (R_DIVD_W),
        .DIVS_W (VW),
        .Q_W    (R_Q_W),
        .PW     ($bits(t_rd_pl))
    ) u_ratio_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (md_valid),
        .i_dividend (md_dvd),
        .i_divisor  (md_dvs),
        .i_payload  (md_pl),
        .o_valid    (rd_valid),
        .o_quot     (rd_quot),
        .o_payload  (rd_pl)
    );

    fcvf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (rd_valid),
        .i_quot    (rd_quot),
        .i_pl      (rd_pl),
        .i_mu      (r_friction_limit),
        .o_valid   (o_res_valid),
        .o_vel     (bk_vel),
        .o_applied (o_contact_applied)
    );

    assign o_new_vel_x = $signed(bk_vel[0]);
    assign o_new_vel_y = $signed(bk_vel[1]);
    assign o_new_vel_z = $signed(bk_vel[2]);

endmodule

[hdl/fcvf_sqrt.sv]
// Pipelined integer square root, one result bit per stage, with a payload carried alongside.
module fcvf_sqrt
    import fcvf_pkg::*;
#(
    parameter int PW = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [SQ_W-1:0]   i_x,
    input  logic [PW-1:0]     i_payload,
    output logic              o_valid,
    output logic [LEN_W-1:0]  o_root,
    output logic [PW-1:0]     o_payload
);

    logic            r_vld [LEN_W];
    logic [SQ_W-1:0] r_x   [LEN_W-1];
    logic [SQ_W-1:0] r_res [LEN_W];
    logic [PW-1:0]   r_pl  [LEN_W];

    for (genvar g = 0; g < LEN_W; g++) begin : g_stage
        localparam int BP = 2 * (LEN_W - 1 - g);
        logic            vld_in;
        logic [SQ_W-1:0] x_in;
        logic [SQ_W-1:0] res_in;
        logic [PW-1:0]   pl_in;
        logic [SQ_W-1:0] bit_v;
        logic [SQ_W-1:0] sum;
        logic [SQ_W-1:0] n_x;
        logic [SQ_W-1:0] n_res;

        if (g == 0) begin : g_head
            assign vld_in = i_valid;
            assign x_in   = i_x;
            assign res_in = '0;
            assign pl_in  = i_payload;
        end else begin : g_body
            assign vld_in = r_vld[g-1];
            assign x_in   = r_x[g-1];
            assign res_in = r_res[g-1];
            assign pl_in  = r_pl[g-1];
        end

        assign bit_v = SQ_W'(1) << BP;
        assign sum   = res_in + bit_v;

        always_comb begin
            if (x_in >= sum) begin
                n_x   = x_in - sum;
                n_res = (res_in >> 1) + bit_v;
            end else begin
                n_x   = x_in;
                n_res = res_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= vld_in;
            end
            r_res[g] <= n_res;
            r_pl[g]  <= pl_in;
        end

        if (g < LEN_W - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                r_x[g] <= n_x;
            end
        end
    end

    assign o_valid   = r_vld[LEN_W-1];
    assign o_root    = r_res[LEN_W-1][LEN_W-1:0];
    assign o_payload = r_pl[LEN_W-1];

endmodule

[hdl/fcvf_udiv.sv]
// Pipelined restoring unsigned divider, one quotient bit per stage, shared divisor across lanes.
module fcvf_udiv #(
    parameter int LANES  = 1,
    parameter int DIVD_W = 48,
    parameter int DIVS_W = 32,
    parameter int Q_W    = 17,
    parameter int PW     = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [LANES-1:0][DIVD_W-1:0] i_dividend,
    input  logic [DIVS_W-1:0]            i_divisor,
    input  logic [PW-1:0]                i_payload,
    output logic                         o_valid,
    output logic [LANES-1:0][Q_W-1:0]    o_quot,
    output logic [PW-1:0]                o_payload
);

    localparam int CW = (DIVD_W > DIVS_W + Q_W) ? DIVD_W : DIVS_W + Q_W;

    logic                          r_vld  [Q_W];
    logic [LANES-1:0][CW-1:0]      r_rem  [Q_W-1];
    logic [LANES-1:0][Q_W-1:0]     r_quot [Q_W];
    logic [DIVS_W-1:0]             r_dvs  [Q_W-1];
    logic [PW-1:0]                 r_pl   [Q_W];

    for (genvar g = 0; g < Q_W; g++) begin : g_stage
        localparam int K = Q_W - 1 - g;
        logic                      vld_in;
        logic [LANES-1:0][CW-1:0]  rem_in;
        logic [LANES-1:0][Q_W-1:0] quot_in;
        logic [DIVS_W-1:0]         dvs_in;
        logic [PW-1:0]             pl_in;
        logic [CW-1:0]             trial;
        logic [LANES-1:0][CW-1:0]  n_rem;
        logic [LANES-1:0][Q_W-1:0] n_quot;

        if (g == 0) begin : g_head
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    rem_in[l] = CW'(i_dividend[l]);
                end
            end
            assign vld_in  = i_valid;
            assign quot_in = '0;
            assign dvs_in  = i_divisor;
            assign pl_in   = i_payload;
        end else begin : g_body
            assign vld_in  = r_vld[g-1];
            assign rem_in  = r_rem[g-1];
            assign quot_in = r_quot[g-1];
            assign dvs_in  = r_dvs[g-1];
            assign pl_in   = r_pl[g-1];
        end

        assign trial = CW'(dvs_in) << K;

        always_comb begin
            n_quot = quot_in;
            for (int l = 0; l < LANES; l++) begin
                if (rem_in[l] >= trial) begin
                    n_rem[l]     = rem_in[l] - trial;
                    n_quot[l][K] = 1'b1;
                end else begin
                    n_rem[l]     = rem_in[l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= vld_in;
            end
            r_quot[g] <= n_quot;
            r_pl[g]   <= pl_in;
        end

        if (g < Q_W - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                r_rem[g] <= n_rem;
                r_dvs[g] <= dvs_in;
            end
        end
    end

    assign o_valid   = r_vld[Q_W-1];
    assign o_quot    = r_quot[Q_W-1];
    assign o_payload = r_pl[Q_W-1];

endmodule

[hdl/fcvf_front.sv]
// Front stages: relative velocity, normal approach speed, tangent and squared tangent length.
module fcvf_front
    import fcvf_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [1:0]      i_mode,
    input  t_w   [2:0]      i_vel,
    input  t_w   [2:0]      i_rigid,
    input  t_w   [2:0]      i_norm,
    input  t_w              i_sep,
    output logic            o_valid,
    output logic [SQ_W-1:0] o_sq,
    output t_sq_pl          o_pl
);

    logic [FRONT_STAGES-1:0] r_vld;

    t_w   [2:0] n1_base, n1_dv, n1_n;
    logic       n1_contact;
    t_w   [2:0] r1_base, r1_v, r1_dv, r1_n;
    logic       r1_contact;

    logic [2:0][63:0] r2_p;
    t_w   [2:0]       r2_base, r2_v, r2_dv, r2_n;
    logic             r2_contact;

    t_w         r3_nd;
    t_w   [2:0] r3_base, r3_v, r3_dv, r3_n;
    logic       r3_contact;

    logic [2:0][63:0] r4_q;
    t_w               r4_nd;
    t_w   [2:0]       r4_base, r4_v, r4_dv;
    logic             r4_contact;

    t_w   [2:0] n5_nn, n5_t;
    t_carry     n5_c;
    t_carry     r5_c;
    t_w   [2:0] r5_t;

    logic [2:0][SQ_W-1:0] r6_sq;
    t_carry               r6_c;
    t_w   [2:0]           r6_t;

    logic [SQ_W-1:0] r7_sq;
    t_sq_pl          r7_pl;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_base[i] = (i_mode == MODE_MASTER) ? i_rigid[i] : i_vel[i];
            n1_dv[i]   = sat32(64'($signed(i_vel[i])) - 64'($signed(i_rigid[i])));
            n1_n[i]    = sat32(-64'($signed(i_norm[i])));
        end
        n1_contact = (i_mode == MODE_CONTACT) && ($signed(i_sep) <= 0);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n5_nn[i]      = sat32($signed(r4_q[i]) >>> 16);
            n5_t[i]       = sat32(64'($signed(r4_dv[i])) - 64'($signed(n5_nn[i])));
            n5_c.vmn[i]   = 33'($signed(r4_v[i])) - 33'($signed(n5_nn[i]));
            n5_c.base[i]  = r4_base[i];
            n5_c.dv[i]    = r4_dv[i];
        end
        n5_c.nd      = r4_nd;
        n5_c.applied = r4_contact && ($signed(r4_nd) > 0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[FRONT_STAGES-2:0], i_valid};
        end

        r1_base    <= n1_base;
        r1_v       <= i_vel;
        r1_dv      <= n1_dv;
        r1_n       <= n1_n;
        r1_contact <= n1_contact;

        for (int i = 0; i < 3; i++) begin
            r2_p[i] <= 64'($signed(r1_dv[i])) * 64'($signed(r1_n[i]));
        end
        r2_base    <= r1_base;
        r2_v       <= r1_v;
        r2_dv      <= r1_dv;
        r2_n       <= r1_n;
        r2_contact <= r1_contact;

        r3_nd      <= sat32(($signed(r2_p[0]) >>> 16) + ($signed(r2_p[1]) >>> 16)
                            + ($signed(r2_p[2]) >>> 16));
        r3_base    <= r2_base;
        r3_v       <= r2_v;
        r3_dv      <= r2_dv;
        r3_n       <= r2_n;
        r3_contact <= r2_contact;

        for (int i = 0; i < 3; i++) begin
            r4_q[i] <= 64'($signed(r3_n[i])) * 64'($signed(r3_nd));
        end
        r4_nd      <= r3_nd;
        r4_base    <= r3_base;
        r4_v       <= r3_v;
        r4_dv      <= r3_dv;
        r4_contact <= r3_contact;

        r5_c <= n5_c;
        r5_t <= n5_t;

        for (int i = 0; i < 3; i++) begin
            r6_sq[i] <= 64'($signed(r5_t[i])) * 64'($signed(r5_t[i]));
        end
        r6_c <= r5_c;
        r6_t <= r5_t;

        r7_sq    <= r6_sq[0] + r6_sq[1] + r6_sq[2];
        r7_pl.c  <= r6_c;
        r7_pl.t  <= r6_t;
    end

    assign o_valid = r_vld[FRONT_STAGES-1];
    assign o_sq    = r7_sq;
    assign o_pl    = r7_pl;

endmodule

[hdl/fcvf_mid.sv]
// Middle stages: signed unit tangent, tangential speed and setup of the friction ratio divide.
module fcvf_mid
    import fcvf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [2:0][U_Q_W-1:0] i_quot,
    input  t_ud_pl                i_pl,
    output logic                  o_valid,
    output logic [R_DIVD_W-1:0]   o_dividend,
    output t_w                    o_divisor,
    output t_rd_pl                o_pl
);

    logic [MID_STAGES-1:0] r_vld;

    logic [2:0][U_W-1:0] n1_u, r1_u, r2_u, r3_u;
    t_carry              r1_c, r2_c, r3_c;
    logic [2:0][M_W-1:0] r2_m;
    logic [TD_W-1:0]     r3_td;
    logic [TD_W-1:0]     n4_abs;
    logic [TDM_W-1:0]    n4_mag;
    logic [R_DIVD_W-1:0] r4_dvd;
    t_rd_pl              r4_pl;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (i_pl.lenz) begin
                n1_u[i] = '0;
            end else if (i_pl.tneg[i]) begin
                n1_u[i] = U_W'(0) - U_W'(i_quot[i]);
            end else begin
                n1_u[i] = U_W'(i_quot[i]);
            end
        end
    end

    always_comb begin
        n4_abs = r3_td[TD_W-1] ? (TD_W'(0) - r3_td) : r3_td;
        n4_mag = n4_abs[TDM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[MID_STAGES-2:0], i_valid};
        end

        r1_u <= n1_u;
        r1_c <= i_pl.c;

        for (int i = 0; i < 3; i++) begin
            r2_m[i] <= M_W'($signed(r1_u[i])) * M_W'($signed(r1_c.dv[i]));
        end
        r2_u <= r1_u;
        r2_c <= r1_c;

        r3_td <= TD_W'(($signed(r2_m[0]) >>> 16) + ($signed(r2_m[1]) >>> 16)
                       + ($signed(r2_m[2]) >>> 16));
        r3_u  <= r2_u;
        r3_c  <= r2_c;

        r4_dvd       <= R_DIVD_W'(n4_mag) << 16;
        r4_pl.c      <= r3_c;
        r4_pl.u      <= r3_u;
        r4_pl.tdneg  <= r3_td[TD_W-1];
        r4_pl.ovf    <= (n4_mag >> 16) >= TDM_W'(r3_c.nd);
    end

    assign o_valid    = r_vld[MID_STAGES-1];
    assign o_dividend = r4_dvd;
    assign o_divisor  = r4_pl.c.nd;
    assign o_pl       = r4_pl;

endmodule

[hdl/fcvf_back.sv]
// Back stages: capped friction factor, friction term and saturated corrected velocity.
module fcvf_back
    import fcvf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [R_Q_W-1:0]  i_quot,
    input  t_rd_pl            i_pl,
    input  logic [MU_W-1:0]   i_mu,
    output logic              o_valid,
    output t_w   [2:0]        o_vel,
    output logic              o_applied
);

    logic [BACK_STAGES-2:0] r_vld;

    t_w                  n1_fc;
    t_w                  r1_fc;
    t_carry              r1_c, r2_c, r3_c, r4_c;
    logic [2:0][U_W-1:0] r1_u, r2_u, r3_u;
    logic [63:0]         r2_fp;
    t_w                  r3_f;
    logic [2:0][M_W-1:0] r4_w;
    t_w   [2:0]          n5_vel;
    t_w   [2:0]          r5_vel;
    logic                r5_vld;
    logic                r5_applied;

    always_comb begin
        if (i_pl.tdneg) begin
            n1_fc = (i_pl.ovf || i_quot[R_Q_W-1]) ? S32_MIN : (VW'(0) - VW'(i_quot));
        end else begin
            n1_fc = (i_pl.ovf || i_quot >= R_Q_W'(i_mu)) ? VW'(i_mu) : VW'(i_quot);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r4_c.applied) begin
                n5_vel[i] = sat32(64'($signed(r4_c.vmn[i])) - 64'($signed(r4_w[i]) >>> 16));
            end else begin
                n5_vel[i] = r4_c.base[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r5_vld     <= 1'b0;
            r5_applied <= 1'b0;
        end else begin
            r_vld      <= {r_vld[BACK_STAGES-3:0], i_valid};
            r5_vld     <= r_vld[BACK_STAGES-2];
            r5_applied <= r_vld[BACK_STAGES-2] && r4_c.applied;
        end

        r1_fc <= n1_fc;
        r1_c  <= i_pl.c;
        r1_u  <= i_pl.u;

        r2_fp <= 64'($signed(r1_fc)) * 64'($signed(r1_c.nd));
        r2_c  <= r1_c;
        r2_u  <= r1_u;

        r3_f  <= sat32($signed(r2_fp) >>> 16);
        r3_c  <= r2_c;
        r3_u  <= r2_u;

        for (int i = 0; i < 3; i++) begin
            r4_w[i] <= M_W'($signed(r3_u[i])) * M_W'($signed(r3_f));
        end
        r4_c <= r3_c;

        r5_vel <= n5_vel;
    end

    assign o_valid   = r5_vld;
    assign o_vel     = r5_vel;
    assign o_applied = r5_applied;

endmodule

[hdl/fcvf_chk.sv]
// Port-level checker for the friction contact velocity fix unit, bound to the top level.
module fcvf_chk
    import fcvf_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic [1:0]       i_item_mode,
    input logic signed [31:0] i_vel_x,
    input logic signed [31:0] i_vel_y,
    input logic signed [31:0] i_vel_z,
    input logic signed [31:0] i_rigid_x,
    input logic signed [31:0] i_rigid_y,
    input logic signed [31:0] i_rigid_z,
    input logic             o_cfg_ready,
    input logic             o_res_valid,
    input logic signed [31:0] o_new_vel_x,
    input logic signed [31:0] o_new_vel_y,
    input logic signed [31:0] o_new_vel_z,
    input logic             o_contact_applied
);

    a_always_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && o_cfg_ready)
        else $error("unit reported not ready");

    a_applied_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_contact_applied |-> o_res_valid)
        else $error("contact flag without result beat");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(start, PIPE_LAT))
        else $error("result beat without matching input beat");

    a_master: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && $past(start && i_item_mode == MODE_MASTER, PIPE_LAT) |->
        o_new_vel_x == $past(i_rigid_x, PIPE_LAT) && o_new_vel_y == $past(i_rigid_y, PIPE_LAT)
        && o_new_vel_z == $past(i_rigid_z, PIPE_LAT) && !o_contact_applied)
        else $error("master beat did not copy rigid velocity");

    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && $past(start && (i_item_mode == MODE_PASS || i_item_mode == MODE_SPARE),
        PIPE_LAT) |->
        o_new_vel_x == $past(i_vel_x, PIPE_LAT) && o_new_vel_y == $past(i_vel_y, PIPE_LAT)
        && o_new_vel_z == $past(i_vel_z, PIPE_LAT) && !o_contact_applied)
        else $error("pass beat changed velocity");

endmodule

bind friction_contact_velocity_fix_unit fcvf_chk u_chk (.*);
